/* sv/sldc_pkg.sv */
// ----------------------------------------------------------------------------
// sldc_pkg
// Shared types and constants for the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package sldc_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned POS_W  = 9;
   localparam int unsigned STAT_W = 2;

   // frame markers
   localparam logic [BYTE_W-1:0] SYNC_FIRST   = 8'd128;
   localparam logic [BYTE_W-1:0] SYNC_SECOND  = 8'd129;
   localparam logic [BYTE_W-1:0] ALT_START    = 8'd181;
   localparam logic [BYTE_W-1:0] SRC_LOW_EXCL = 8'd120;
   localparam logic [BYTE_W-1:0] SRC_KNOWN    = 8'h7F;
   // header bytes plus checksum byte, minus one: last position = N + 5
   localparam logic [POS_W-1:0]  LAST_OFFSET  = 9'd5;

   // fixed header positions
   localparam logic [POS_W-1:0] POS_SYNC0  = 9'd0;
   localparam logic [POS_W-1:0] POS_SYNC1  = 9'd1;
   localparam logic [POS_W-1:0] POS_SOURCE = 9'd2;
   localparam logic [POS_W-1:0] POS_PGN    = 9'd3;
   localparam logic [POS_W-1:0] POS_LENGTH = 9'd4;

   // status on the last byte
   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_CSUM_ERR = 2'd1,
      STAT_UNKNOWN  = 2'd2
   } status_type;

   // one result transfer
   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic [POS_W-1:0]  byte_position;
      logic              is_last;
      status_type        frame_status;
   } rsp_type;

endpackage

/* sv/sldc_parse.sv */
// ----------------------------------------------------------------------------
// sldc_parse
// Frame hunter: holds the frame state and, for each accepted byte, computes
// the next state and the result (if any) in one pass of logic.
// ----------------------------------------------------------------------------
module sldc_parse (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,      // byte accepted this cycle
   input  logic [sldc_pkg::BYTE_W-1:0]      rx_byte,
   output logic                             res_valid, // this byte produces a result
   output sldc_pkg::rsp_type                res
);

   // frame state
   logic [sldc_pkg::POS_W-1:0]  position_ff, position_in;
   logic [sldc_pkg::BYTE_W-1:0] length_ff, length_in;
   logic [sldc_pkg::BYTE_W-1:0] sum_ff, sum_in;
   logic                        alt_ff, alt_in;
   logic [sldc_pkg::BYTE_W-1:0] source_ff, source_in;

   logic [sldc_pkg::POS_W-1:0]  last_pos;
   logic [sldc_pkg::BYTE_W-1:0] sum_add;

   assign last_pos = {1'b0, length_ff} + sldc_pkg::LAST_OFFSET;
   assign sum_add  = sum_ff + rx_byte;

   // next state and result
   always_comb begin
      position_in = position_ff;
      length_in   = length_ff;
      sum_in      = sum_ff;
      alt_in      = alt_ff;
      source_in   = source_ff;
      res_valid   = 1'b0;
      res.frame_byte    = rx_byte;
      res.byte_position = position_ff;
      res.is_last       = 1'b0;
      res.frame_status  = sldc_pkg::STAT_OK;

      case (position_ff)
         sldc_pkg::POS_SYNC0: begin
            // hunting for the first sync
            if (rx_byte == sldc_pkg::SYNC_FIRST) begin
               alt_in      = 1'b0;
               sum_in      = '0;
               position_in = sldc_pkg::POS_SYNC1;
               res_valid   = 1'b1;
            end
         end
         sldc_pkg::POS_SYNC1: begin
            if (rx_byte == sldc_pkg::SYNC_SECOND) begin
               sum_in      = '0;
               position_in = sldc_pkg::POS_SOURCE;
               res_valid   = 1'b1;
            end else if (rx_byte == sldc_pkg::ALT_START) begin
               // alternate start restarts the frame, still waiting for sync 2
               alt_in            = 1'b1;
               sum_in            = '0;
               res_valid         = 1'b1;
               res.byte_position = sldc_pkg::POS_SYNC0;
            end else begin
               position_in = sldc_pkg::POS_SYNC0;
            end
         end
         sldc_pkg::POS_SOURCE: begin
            if (rx_byte > sldc_pkg::SRC_LOW_EXCL && rx_byte < sldc_pkg::SYNC_FIRST) begin
               source_in   = rx_byte;
               sum_in      = rx_byte;
               position_in = sldc_pkg::POS_PGN;
               res_valid   = 1'b1;
            end else begin
               position_in = sldc_pkg::POS_SYNC0;
            end
         end
         sldc_pkg::POS_PGN: begin
            sum_in      = sum_add;
            position_in = sldc_pkg::POS_LENGTH;
            res_valid   = 1'b1;
         end
         sldc_pkg::POS_LENGTH: begin
            length_in   = rx_byte;
            sum_in      = sum_add;
            position_in = position_ff + 1'b1;
            res_valid   = 1'b1;
         end
         default: begin
            // data bytes, then the checksum byte
            res_valid = 1'b1;
            if (position_ff < last_pos) begin
               sum_in      = sum_add;
               position_in = position_ff + 1'b1;
            end else begin
               res.is_last = 1'b1;
               position_in = sldc_pkg::POS_SYNC0;
               if (alt_ff)
                  res.frame_status = sldc_pkg::STAT_UNKNOWN;
               else if (rx_byte != sum_ff)
                  res.frame_status = sldc_pkg::STAT_CSUM_ERR;
               else if (source_ff != sldc_pkg::SRC_KNOWN)
                  res.frame_status = sldc_pkg::STAT_UNKNOWN;
               else
                  res.frame_status = sldc_pkg::STAT_OK;
            end
         end
      endcase
   end

   // state registers, updated only on an accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         length_ff   <= '0;
         sum_ff      <= '0;
         alt_ff      <= 1'b0;
         source_ff   <= '0;
      end else if (step) begin
         position_ff <= position_in;
         length_ff   <= length_in;
         sum_ff      <= sum_in;
         alt_ff      <= alt_in;
         source_ff   <= source_in;
      end
   end

endmodule

/* sv/sync_length_checksum_deframer_core.sv */
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_core
// Results are registered on rsp_; one byte per cycle is taken while req_stall
// is low, and the result register plus a one-entry skid stage let a byte be
// taken while a previous result is still stalled. req_stall rises only when
// both the result register and the skid are full.
// Reset (synchronous, active high) returns to hunting and empties the output.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_core (
   input  logic                             clock,
   input  logic                             reset,
   // byte input
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sldc_pkg::BYTE_W-1:0]      req_rx_byte,
   // frame byte output
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sldc_pkg::BYTE_W-1:0]      rsp_frame_byte,
   output logic [sldc_pkg::POS_W-1:0]       rsp_byte_position,
   output logic                             rsp_is_last,
   output logic [sldc_pkg::STAT_W-1:0]      rsp_frame_status
);

   logic              req_take;
   logic              res_valid;
   sldc_pkg::rsp_type res;

   logic              out_valid_ff;
   sldc_pkg::rsp_type out_ff;
   logic              skid_valid_ff;
   sldc_pkg::rsp_type skid_ff;
   logic              out_take;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;

   sldc_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (req_take),
      .rx_byte   (req_rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   // output register and skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_take && res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_ff       <= res;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= res;
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_frame_byte    = out_ff.frame_byte;
   assign rsp_byte_position = out_ff.byte_position;
   assign rsp_is_last       = out_ff.is_last;
   assign rsp_frame_status  = out_ff.frame_status;

endmodule

/* sv/sldc_checker.sv */
// ----------------------------------------------------------------------------
// sldc_checker
// Port-level checks on the deframer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module sldc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [sldc_pkg::BYTE_W-1:0]  rsp_frame_byte,
   input logic [sldc_pkg::POS_W-1:0]   rsp_byte_position,
   input logic                         rsp_is_last,
   input logic [sldc_pkg::STAT_W-1:0]  rsp_frame_status
);

   // a stalled result transfer holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_byte)
         && $stable(rsp_byte_position) && $stable(rsp_is_last))
      else $error("stalled result changed");

   // a non-ok status only on the frame's last byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_last |-> rsp_frame_status == sldc_pkg::STAT_OK)
      else $error("status set on a non-last byte");

   // the last byte always follows the full header
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_last |-> rsp_byte_position >= sldc_pkg::LAST_OFFSET)
      else $error("last byte inside header");

   // frame starts carry a start marker, position one carries sync 2
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_position == sldc_pkg::POS_SYNC0 |->
         rsp_frame_byte == sldc_pkg::SYNC_FIRST || rsp_frame_byte == sldc_pkg::ALT_START)
      else $error("bad start byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_position == sldc_pkg::POS_SYNC1 |->
         rsp_frame_byte == sldc_pkg::SYNC_SECOND)
      else $error("bad second sync byte");

endmodule

bind sync_length_checksum_deframer_core sldc_checker u_sldc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_frame_byte    (rsp_frame_byte),
   .rsp_byte_position (rsp_byte_position),
   .rsp_is_last       (rsp_is_last),
   .rsp_frame_status  (rsp_frame_status)
);

/* dv/sync_length_checksum_deframer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_core_tb
// Streams well-formed, broken and noisy byte sequences into the deframer with
// random idles on both sides and two long output hold-offs. A local frame
// tracker predicts each echoed byte, its position, the last flag and the
// status, and every result transfer is checked in order against it.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_core_tb;

   typedef logic [sldc_pkg::BYTE_W-1:0] byte_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   byte_type                    req_rx_byte = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   byte_type                    rsp_frame_byte;
   logic [sldc_pkg::POS_W-1:0]  rsp_byte_position;
   logic                        rsp_is_last;
   logic [sldc_pkg::STAT_W-1:0] rsp_frame_status;

   // byte stream waiting to go out, and results still owed by the block
   byte_type                    rx_stream[$];
   sldc_pkg::rsp_type           expected_bytes[$];

   // frame tracker state
   logic [sldc_pkg::POS_W-1:0]  hunt_pos;
   byte_type                    frame_len;
   byte_type                    frame_sum;
   logic                        frame_alt;
   byte_type                    frame_src;

   int unsigned         bytes_sent = 0;
   int unsigned         stim_total = 0;
   int unsigned         framed_count = 0;
   int unsigned         mismatch_count = 0;
   int unsigned         feed_gap = 0;
   int unsigned         feed_calm = 0;
   int unsigned         sink_gap = 0;
   int unsigned         sink_calm = 0;
   logic                hold_all = 1'b0;

   sync_length_checksum_deframer_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_is_last       (rsp_is_last),
      .rsp_frame_status  (rsp_frame_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Idle length: mostly none or short, a few long, and calm stretches of none
   function automatic int unsigned pick_idle(inout int unsigned calm_left);
      int unsigned roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Track one accepted byte through the hunt and frame states
   function automatic void deframe_predict(input byte_type b);
      sldc_pkg::rsp_type          r;
      logic                       emit_it;
      logic [sldc_pkg::POS_W-1:0] last_at;
      emit_it         = 1'b1;
      r.frame_byte    = b;
      r.byte_position = hunt_pos;
      r.is_last       = 1'b0;
      r.frame_status  = sldc_pkg::STAT_OK;
      last_at         = {1'b0, frame_len} + sldc_pkg::LAST_OFFSET;
      case (hunt_pos)
         sldc_pkg::POS_SYNC0: begin
            if (b == sldc_pkg::SYNC_FIRST) begin
               frame_alt = 1'b0;
               frame_sum = '0;
               hunt_pos  = sldc_pkg::POS_SYNC1;
            end else begin
               emit_it = 1'b0;
            end
         end
         sldc_pkg::POS_SYNC1: begin
            if (b == sldc_pkg::SYNC_SECOND) begin
               frame_sum = '0;
               hunt_pos  = sldc_pkg::POS_SOURCE;
            end else if (b == sldc_pkg::ALT_START) begin
               // alternate start restarts the frame, still waiting on sync two
               frame_alt       = 1'b1;
               frame_sum       = '0;
               r.byte_position = sldc_pkg::POS_SYNC0;
            end else begin
               emit_it  = 1'b0;
               hunt_pos = sldc_pkg::POS_SYNC0;
            end
         end
         sldc_pkg::POS_SOURCE: begin
            if (b > sldc_pkg::SRC_LOW_EXCL && b < sldc_pkg::SYNC_FIRST) begin
               frame_src = b;
               frame_sum = b;
               hunt_pos  = sldc_pkg::POS_PGN;
            end else begin
               emit_it  = 1'b0;
               hunt_pos = sldc_pkg::POS_SYNC0;
            end
         end
         sldc_pkg::POS_PGN, sldc_pkg::POS_LENGTH: begin
            if (hunt_pos == sldc_pkg::POS_LENGTH) frame_len = b;
            frame_sum = frame_sum + b;
            hunt_pos  = hunt_pos + 1'b1;
         end
         default: begin
            if (hunt_pos < last_at) begin
               frame_sum = frame_sum + b;
               hunt_pos  = hunt_pos + 1'b1;
            end else begin
               r.is_last = 1'b1;
               if (frame_alt)
                  r.frame_status = sldc_pkg::STAT_UNKNOWN;
               else if (b != frame_sum)
                  r.frame_status = sldc_pkg::STAT_CSUM_ERR;
               else if (frame_src != sldc_pkg::SRC_KNOWN)
                  r.frame_status = sldc_pkg::STAT_UNKNOWN;
               else
                  r.frame_status = sldc_pkg::STAT_OK;
               hunt_pos = sldc_pkg::POS_SYNC0;
            end
         end
      endcase
      if (emit_it) expected_bytes.push_back(r);
   endfunction

   // Queue a complete frame with random data bytes
   function automatic void queue_frame(input bit alt, input byte_type src,
                                       input byte_type pgn,
                                       input byte_type len, input bit bad_sum);
      byte_type sum;
      byte_type data;
      byte_type skew;
      rx_stream.push_back(sldc_pkg::SYNC_FIRST);
      if (alt) rx_stream.push_back(sldc_pkg::ALT_START);
      rx_stream.push_back(sldc_pkg::SYNC_SECOND);
      rx_stream.push_back(src);
      rx_stream.push_back(pgn);
      rx_stream.push_back(len);
      sum = src + pgn + len;
      for (int i = 0; i < len; i++) begin
         data = byte_type'($urandom_range(0, 255));
         sum  = sum + data;
         rx_stream.push_back(data);
      end
      skew = byte_type'($urandom_range(1, 255));
      rx_stream.push_back(bad_sum ? byte_type'(sum + skew) : sum);
      framed_count += len + 6 + alt;
   endfunction

   // Random bytes leaning toward the marker values
   function automatic void queue_noise(input int unsigned count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 5))
            0:       rx_stream.push_back(sldc_pkg::SYNC_FIRST);
            1:       rx_stream.push_back(sldc_pkg::SYNC_SECOND);
            2:       rx_stream.push_back(sldc_pkg::ALT_START);
            default: rx_stream.push_back(byte_type'($urandom_range(0, 255)));
         endcase
      end
   endfunction

   // Header fragments that break off at a random point
   function automatic void queue_broken();
      rx_stream.push_back(sldc_pkg::SYNC_FIRST);
      case ($urandom_range(0, 3))
         0: rx_stream.push_back(byte_type'($urandom_range(0, 255)));
         1: begin
            rx_stream.push_back(sldc_pkg::SYNC_SECOND);
            rx_stream.push_back(byte_type'($urandom_range(0, 255)));
         end
         2: begin
            rx_stream.push_back(sldc_pkg::ALT_START);
            rx_stream.push_back(byte_type'($urandom_range(0, 255)));
         end
         default: begin
            rx_stream.push_back(sldc_pkg::SYNC_SECOND);
            rx_stream.push_back(byte_type'($urandom_range(sldc_pkg::SRC_LOW_EXCL + 1,
                                                          sldc_pkg::SRC_KNOWN)));
            rx_stream.push_back(byte_type'($urandom_range(0, 255)));
         end
      endcase
   endfunction

   // Driver: one pending byte offered at a time, held until taken
   always @(posedge clock) begin : feed
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
         hunt_pos  = sldc_pkg::POS_SYNC0;
         frame_len = '0;
         frame_sum = '0;
         frame_alt = 1'b0;
         frame_src = '0;
      end else begin
         offer = req_valid;
         if (req_valid && !req_stall) begin
            deframe_predict(req_rx_byte);
            bytes_sent++;
            offer = 1'b0;
         end
         if (!offer) begin
            if (feed_gap > 0) begin
               feed_gap--;
            end else if (rx_stream.size() > 0) begin
               req_rx_byte <= rx_stream.pop_front();
               offer    = 1'b1;
               feed_gap = pick_idle(feed_calm);
            end
         end
         req_valid <= offer;
      end
   end

   // Monitor: compare each result transfer with the oldest expectation
   always @(posedge clock) begin : sink
      sldc_pkg::rsp_type want;
      logic              stall_now;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               flag_mismatch($sformatf("unexpected transfer byte %02h pos %0d",
                                       rsp_frame_byte, rsp_byte_position));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_frame_byte !== want.frame_byte)
                  flag_mismatch($sformatf("frame_byte %02h, want %02h",
                                          rsp_frame_byte, want.frame_byte));
               if (rsp_byte_position !== want.byte_position)
                  flag_mismatch($sformatf("byte_position %0d, want %0d",
                                          rsp_byte_position, want.byte_position));
               if (rsp_is_last !== want.is_last)
                  flag_mismatch($sformatf("is_last %b, want %b at pos %0d",
                                          rsp_is_last, want.is_last, want.byte_position));
               if (rsp_frame_status !== want.frame_status)
                  flag_mismatch($sformatf("frame_status %0d, want %0d at pos %0d",
                                          rsp_frame_status, want.frame_status,
                                          want.byte_position));
            end
         end
         if (sink_gap > 0) begin
            sink_gap--;
            stall_now = 1'b1;
         end else begin
            stall_now = 1'b0;
            sink_gap  = pick_idle(sink_calm);
         end
         rsp_stall <= stall_now || hold_all;
      end
   end

   // Long output hold-offs while bytes keep coming, to back up the input
   initial begin : backlog
      for (int k = 0; k < 2; k++) begin
         wait (bytes_sent >= 100 + 350 * k);
         @(posedge clock);
         hold_all <= 1'b1;
         repeat (90) @(posedge clock);
         hold_all <= 1'b0;
      end
   end

   initial begin : limit
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : main
      int unsigned pick;
      int unsigned drain;
      bit          big_done;
      byte_type    src;
      byte_type    len;

      // directed: hunting noise, sync two mismatch on a first sync byte,
      // bad source, then ok, alternate start, checksum error, unknown source
      rx_stream.push_back(8'h00);
      rx_stream.push_back(8'hFF);
      rx_stream.push_back(sldc_pkg::SYNC_FIRST);
      rx_stream.push_back(sldc_pkg::SYNC_FIRST);
      rx_stream.push_back(sldc_pkg::SYNC_FIRST);
      rx_stream.push_back(sldc_pkg::SYNC_SECOND);
      rx_stream.push_back(sldc_pkg::SRC_LOW_EXCL);
      queue_frame(1'b0, sldc_pkg::SRC_KNOWN, 8'h00, 8'd0, 1'b0);
      queue_frame(1'b1, sldc_pkg::SRC_KNOWN, 8'hFF, 8'd1, 1'b0);
      queue_frame(1'b0, sldc_pkg::SRC_LOW_EXCL + 8'd1, 8'h55, 8'd0, 1'b1);
      queue_frame(1'b0, sldc_pkg::SRC_LOW_EXCL + 8'd1, 8'hAA, 8'd2, 1'b0);

      // random: mostly frames with small payloads, one of maximum length
      big_done = 1'b0;
      while (framed_count < 550) begin
         pick = $urandom_range(0, 99);
         src  = ($urandom_range(0, 1) == 1)
                   ? sldc_pkg::SRC_KNOWN
                   : byte_type'($urandom_range(sldc_pkg::SRC_LOW_EXCL + 1,
                                               sldc_pkg::SRC_KNOWN - 1));
         if (!big_done && framed_count > 200) begin
            queue_frame(1'b0, src, byte_type'($urandom_range(0, 255)), 8'd255,
                        $urandom_range(0, 1) == 1);
            big_done = 1'b1;
         end else if (pick < 72) begin
            len = ($urandom_range(0, 3) != 0) ? byte_type'($urandom_range(0, 8))
                                              : byte_type'($urandom_range(9, 40));
            queue_frame($urandom_range(0, 99) < 15, src,
                        byte_type'($urandom_range(0, 255)), len,
                        $urandom_range(0, 99) < 20);
         end else if (pick < 86) begin
            queue_noise($urandom_range(1, 6));
         end else begin
            queue_broken();
         end
      end
      stim_total = rx_stream.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (bytes_sent == stim_total);
      drain = 0;
      while (expected_bytes.size() != 0 && drain < 4000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (expected_bytes.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", expected_bytes.size()));

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* files.f */
sv/sldc_pkg.sv
sv/sldc_parse.sv
sv/sync_length_checksum_deframer_core.sv
sv/sldc_checker.sv
dv/sync_length_checksum_deframer_core_tb.sv
